// File: rtl/core/slspd_pkg.sv
package slspd_pkg;

  // Longest payload that is taken; a longer length byte drops the frame.
  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned STORE_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [8:0] MAX_LEN_W = 9'(MAX_LEN);

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_READ    = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_BAD    = 2'd2,
    EV_LENGTH = 2'd3
  } event_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       new_message;
    logic       wrong_data;
    logic [7:0] frame_length;
    logic [7:0] data_byte;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

endpackage

// File: rtl/core/slspd_if.sv
interface slspd_in_if;
  import slspd_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, req_type, rx_byte, read_index, input ready);
  modport sink (input valid, req_type, rx_byte, read_index, output ready);
endinterface

interface slspd_out_if;
  import slspd_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       new_message;
  logic       wrong_data;
  logic [7:0] frame_length;
  logic [7:0] data_byte;

  modport source (output valid, event_code, new_message, wrong_data, frame_length,
                  data_byte, input ready);
  modport sink (input valid, event_code, new_message, wrong_data, frame_length,
                data_byte, output ready);
endinterface

// File: rtl/core/slspd_store.sv
module slspd_store
  import slspd_pkg::*;
(
  input  logic                clk_i,
  input  store_wr_t           wr_i,
  input  logic                rd_en_i,
  input  logic [STORE_AW-1:0] rd_addr_i,
  output logic [7:0]          rd_data_o
);

  logic [7:0] mem [MAX_LEN];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Write-first: a read issued on the edge of a write to the same entry sees the new byte.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/slspd_ctrl.sv
module slspd_ctrl
  import slspd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  item_t      item_i,
  input  logic [7:0] rd_data_i,
  output store_wr_t  wr_o,
  output result_t    result_o
);

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_SUM   = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic       msg_q, msg_d;
  logic       bad_q, bad_d;
  logic [1:0] ev;
  logic [7:0] count_inc;
  logic [7:0] data;

  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    sum_d   = sum_q;
    msg_d   = msg_q;
    bad_d   = bad_q;
    ev      = EV_NONE;
    data    = 8'd0;
    wr_o.en   = 1'b0;
    wr_o.addr = count_q[STORE_AW-1:0];
    wr_o.data = item_i.rx_byte;

    case (item_i.req_type)
      REQ_BYTE: begin
        case (phase_q)
          PH_SYNC1: begin
            if (item_i.rx_byte == SYNC_BYTE) begin
              phase_d = PH_SYNC2;
            end else begin
              bad_d = 1'b1;
              ev    = EV_BAD;
            end
          end
          PH_SYNC2: begin
            if (item_i.rx_byte == SYNC_BYTE) begin
              phase_d = PH_LEN;
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_SYNC1;
              ev      = EV_BAD;
            end
          end
          PH_LEN: begin
            len_d = item_i.rx_byte;
            if ({1'b0, item_i.rx_byte} > MAX_LEN_W) begin
              phase_d = PH_SYNC1;
              ev      = EV_LENGTH;
            end else begin
              sum_d   = 8'd0;
              count_d = 8'd0;
              phase_d = (item_i.rx_byte == 8'd0) ? PH_SUM : PH_DATA;
            end
          end
          PH_DATA: begin
            wr_o.en = advance_i && ({1'b0, count_q} < MAX_LEN_W);
            sum_d   = sum_q + item_i.rx_byte;
            count_d = count_inc;
            if (count_inc >= len_q) begin
              phase_d = PH_SUM;
            end
          end
          PH_SUM: begin
            phase_d = PH_SYNC1;
            if (sum_q == item_i.rx_byte) begin
              msg_d = 1'b1;
              ev    = EV_ACCEPT;
            end else begin
              bad_d = 1'b1;
              ev    = EV_BAD;
            end
          end
          default: begin
            phase_d = PH_SYNC1;
          end
        endcase
      end
      REQ_READ: begin
        if ((item_i.read_index < len_q) && ({1'b0, item_i.read_index} < MAX_LEN_W)) begin
          data = rd_data_i;
        end
      end
      REQ_QUERY: begin
        if (bad_q) begin
          msg_d = 1'b0;
        end
      end
      default: begin
        msg_d = 1'b0;
      end
    endcase
  end

  assign result_o.event_code   = ev;
  assign result_o.new_message  = msg_d;
  assign result_o.wrong_data   = bad_d;
  assign result_o.frame_length = len_d;
  assign result_o.data_byte    = data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      count_q <= 8'd0;
      len_q   <= 8'd0;
      sum_q   <= 8'd0;
      msg_q   <= 1'b0;
      bad_q   <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      msg_q   <= msg_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// File: rtl/core/sync_length_sum_packet_deframer.sv
// Frame deframer for the byte stream AA AA len payload[len] sum, where sum is the
// 8-bit wrapping sum of the payload. Every input item gives exactly one result item.
// An item is taken into an input register on the cycle it is offered while the
// payload store is read at its read_index; when the working stage advances, the frame
// state is updated and the result lands in the output register, from which it is
// offered, and one item is taken every cycle while the output side keeps up.
// While the output is stalled the result and the input register hold, and the input
// drops ready once both are full. The
// store is a single-write, single-read memory of MAX_LEN bytes with a registered
// read port; it is never cleared, so reading a position that no frame has written
// returns an arbitrary byte. The new-message flag is cleared by a release, or by a
// query while the wrong-data flag is set; the wrong-data flag only clears at reset.
module sync_length_sum_packet_deframer
  import slspd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  slspd_in_if.sink    rx_i,
  slspd_out_if.source res_o
);

  item_t      s1_q;
  logic       s1_valid_q;
  result_t    out_q;
  logic       out_valid_q;
  logic       out_free;
  logic       advance;
  logic       accept;
  logic [7:0] rd_data;
  store_wr_t  wr;
  result_t    result;

  // Advance the working stage whenever it holds an item and the output register is empty or being emptied.
  assign out_free = !out_valid_q || res_o.ready;
  assign advance  = s1_valid_q && out_free;
  assign rx_i.ready = !s1_valid_q || out_free;
  assign accept   = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  // Hold the item while the stage stalls; capture only on acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.req_type   <= rx_i.req_type;
      s1_q.rx_byte    <= rx_i.rx_byte;
      s1_q.read_index <= rx_i.read_index;
    end
  end

  slspd_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (accept),
    .rd_addr_i (rx_i.read_index[STORE_AW-1:0]),
    .rd_data_o (rd_data)
  );

  slspd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_q),
    .rd_data_i (rd_data),
    .wr_o      (wr),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.event_code   = out_q.event_code;
  assign res_o.new_message  = out_q.new_message;
  assign res_o.wrong_data   = out_q.wrong_data;
  assign res_o.frame_length = out_q.frame_length;
  assign res_o.data_byte    = out_q.data_byte;

  // An accepted frame leaves a message waiting.
  a_accept_sets_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.event_code == EV_ACCEPT)) |-> res_o.new_message)
    else $error("frame accepted without new_message");

  // Malformed data raises the sticky flag.
  a_bad_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.event_code == EV_BAD)) |-> res_o.wrong_data)
    else $error("bad data without wrong_data");

  // A rejected length always exceeds the store size.
  a_len_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.event_code == EV_LENGTH)) |->
      ({1'b0, res_o.frame_length} > MAX_LEN_W))
    else $error("length rejected within limit");

  // A working item reaches the output register on the edge it advances.
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_o.valid)
    else $error("advanced item lost");

endmodule

// File: test/tb_sync_length_sum_packet_deframer.sv
module tb_sync_length_sum_packet_deframer;
  import slspd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Two copies of the frame state: PLAN follows the items as they are queued,
  // so that no read is ever aimed at a store entry that no frame has filled;
  // LIVE follows the items as the block accepts them and gives the expectations.
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  localparam int RANDOM_ITEMS = 1300;
  localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
  localparam int HOLD_AT      = 300;   // accepted items before the hold-off
  localparam int CALM_TAIL    = 150;   // last items run with no idling
  localparam int DRAIN_CYCLES = 10;    // settling time after the last result

  typedef enum logic [2:0] {
    HUNT_SYNC1,
    HUNT_SYNC2,
    TAKE_LEN,
    TAKE_DATA,
    TAKE_SUM
  } hunt_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  slspd_in_if  rx_if ();
  slspd_out_if res_if ();

  sync_length_sum_packet_deframer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Frame state, one copy per index (PLAN, LIVE).
  hunt_e      frm_phase   [2];
  logic [7:0] frm_count   [2];
  logic [7:0] frm_len     [2];
  logic [7:0] frm_sum     [2];
  logic [7:0] frm_store   [2][MAX_LEN];
  bit         frm_written [2][MAX_LEN];
  logic       frm_msg     [2];
  logic       frm_bad     [2];

  item_t   pending_items [$];
  result_t expected_results [$];

  int total_items = 0;
  int taken_cnt   = 0;
  int offered_cnt = 0;
  int fail_cnt    = 0;
  int send_gap    = 0;
  int stall_left  = 0;
  bit hold_done   = 1'b0;
  bit calm;

  // Idling stops for the last stretch of the run.
  assign calm = (taken_cnt + CALM_TAIL >= total_items);

  // Advance one copy of the frame state by one item and return its result.
  function automatic result_t frame_step(input int m, input item_t it);
    result_t    r;
    logic [7:0] b;
    r = '0;
    b = it.rx_byte;
    r.event_code = EV_NONE;
    case (req_e'(it.req_type))
      REQ_BYTE: begin
        case (frm_phase[m])
          HUNT_SYNC1: begin
            if (b == SYNC_BYTE) begin
              frm_phase[m] = HUNT_SYNC2;
            end else begin
              frm_bad[m] = 1'b1;
              r.event_code = EV_BAD;
            end
          end
          HUNT_SYNC2: begin
            if (b == SYNC_BYTE) begin
              frm_phase[m] = TAKE_LEN;
            end else begin
              frm_bad[m] = 1'b1;
              frm_phase[m] = HUNT_SYNC1;
              r.event_code = EV_BAD;
            end
          end
          TAKE_LEN: begin
            // the length is kept even when it is rejected
            frm_len[m] = b;
            if (9'(b) > MAX_LEN_W) begin
              frm_phase[m] = HUNT_SYNC1;
              r.event_code = EV_LENGTH;
            end else begin
              frm_sum[m]   = 8'h00;
              frm_count[m] = 8'h00;
              frm_phase[m] = (b == 8'h00) ? TAKE_SUM : TAKE_DATA;
            end
          end
          TAKE_DATA: begin
            if (frm_count[m] < MAX_LEN) begin
              frm_store[m][frm_count[m]]   = b;
              frm_written[m][frm_count[m]] = 1'b1;
            end
            frm_sum[m]   = frm_sum[m] + b;
            frm_count[m] = frm_count[m] + 8'd1;
            if (frm_count[m] >= frm_len[m]) frm_phase[m] = TAKE_SUM;
          end
          TAKE_SUM: begin
            frm_phase[m] = HUNT_SYNC1;
            if (frm_sum[m] == b) begin
              frm_msg[m] = 1'b1;
              r.event_code = EV_ACCEPT;
            end else begin
              frm_bad[m] = 1'b1;
              r.event_code = EV_BAD;
            end
          end
          default: frm_phase[m] = HUNT_SYNC1;
        endcase
      end
      REQ_READ: begin
        if (it.read_index < frm_len[m] && it.read_index < MAX_LEN)
          r.data_byte = frm_store[m][it.read_index];
      end
      REQ_QUERY: begin
        if (frm_bad[m]) frm_msg[m] = 1'b0;
      end
      default: frm_msg[m] = 1'b0;
    endcase
    r.new_message  = frm_msg[m];
    r.wrong_data   = frm_bad[m];
    r.frame_length = frm_len[m];
    return r;
  endfunction

  // Queue one item. Redirect a read of a never-filled entry to the first
  // position past the stored length, which reads as zero.
  task automatic queue_item(input req_e req, input logic [7:0] b, input logic [7:0] idx);
    item_t it;
    if (req == REQ_READ && idx < frm_len[PLAN] && idx < MAX_LEN && !frm_written[PLAN][idx])
      idx = frm_len[PLAN];
    it.req_type   = req;
    it.rx_byte    = b;
    it.read_index = idx;
    void'(frame_step(PLAN, it));
    pending_items.push_back(it);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_item(REQ_BYTE, b, 8'($urandom));
  endtask

  // A read, a query or a release, with random unused fields.
  task automatic queue_side();
    logic [7:0] idx;
    idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 70)) : 8'($urandom);
    queue_item(req_e'($urandom_range(1, 3)), 8'($urandom), idx);
  endtask

  // A whole frame with random payload; side requests drop in between bytes.
  task automatic queue_frame(input int unsigned n, input bit bad_sum);
    logic [7:0] s;
    logic [7:0] b;
    s = 8'h00;
    queue_byte(SYNC_BYTE);
    queue_byte(SYNC_BYTE);
    queue_byte(8'(n));
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      s = s + b;
      queue_byte(b);
      if ($urandom_range(0, 7) == 0) queue_side();
    end
    queue_byte(bad_sum ? s + 8'($urandom_range(1, 255)) : s);
  endtask

  task automatic queue_random_part();
    int unsigned pick;
    int unsigned n;
    while (pending_items.size() < total_items + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        // frames, mostly short and well-formed; a few at full length
        case ($urandom_range(0, 19))
          0:       n = MAX_LEN;
          1:       n = $urandom_range(13, MAX_LEN);
          2:       n = 0;
          default: n = $urandom_range(1, 12);
        endcase
        queue_frame(n, $urandom_range(0, 7) == 0);
      end else if (pick < 14) begin
        repeat ($urandom_range(1, 4)) queue_item(REQ_READ, 8'($urandom),
                                                 ($urandom_range(0, 3) == 0) ?
                                                 8'($urandom) : 8'($urandom_range(0, 15)));
      end else if (pick < 16) begin
        queue_item(($urandom_range(0, 1) == 0) ? REQ_QUERY : REQ_RELEASE,
                   8'($urandom), 8'($urandom));
      end else if (pick < 17) begin
        queue_byte(SYNC_BYTE);
        queue_byte(SYNC_BYTE);
        queue_byte(8'($urandom_range(MAX_LEN + 1, 255)));
      end else if (pick < 18) begin
        // broken second sync byte
        queue_byte(SYNC_BYTE);
        queue_byte(8'($urandom_range(0, 8'hA9)));
      end else begin
        // line noise
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end
    end
  endtask

  // Sender: offer the next item once the one on the bus has been taken,
  // and hold valid low through a random gap now and then.
  always @(negedge clk) begin : feed_items
    item_t nxt;
    if (rst_n && taken_cnt == offered_cnt) begin
      if (send_gap > 0) begin
        send_gap--;
        rx_if.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        rx_if.valid      <= 1'b1;
        rx_if.req_type   <= nxt.req_type;
        rx_if.rx_byte    <= nxt.rx_byte;
        rx_if.read_index <= nxt.read_index;
        offered_cnt++;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so that the block backs
  // up and drops ready on its input side while the sender keeps offering.
  always @(negedge clk) begin : drain_results
    if (rst_n) begin
      if (!hold_done && taken_cnt >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Predict the result of every item the block accepts.
  always @(posedge clk) begin : predict_items
    item_t it;
    if (rst_n && rx_if.valid && rx_if.ready) begin
      it.req_type   = rx_if.req_type;
      it.rx_byte    = rx_if.rx_byte;
      it.read_index = rx_if.read_index;
      expected_results.push_back(frame_step(LIVE, it));
      taken_cnt++;
    end
  end

  // Compare every accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (res_if.event_code !== want.event_code) begin
          $error("event_code: expected %0d, got %0d", want.event_code, res_if.event_code);
          fail_cnt++;
        end
        if (res_if.new_message !== want.new_message) begin
          $error("new_message: expected %0d, got %0d", want.new_message, res_if.new_message);
          fail_cnt++;
        end
        if (res_if.wrong_data !== want.wrong_data) begin
          $error("wrong_data: expected %0d, got %0d", want.wrong_data, res_if.wrong_data);
          fail_cnt++;
        end
        if (res_if.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 res_if.frame_length);
          fail_cnt++;
        end
        if (res_if.data_byte !== want.data_byte) begin
          $error("data_byte: expected %0d, got %0d", want.data_byte, res_if.data_byte);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rx_if.valid      = 1'b0;
    rx_if.req_type   = REQ_BYTE;
    rx_if.rx_byte    = 8'h00;
    rx_if.read_index = 8'h00;
    res_if.ready     = 1'b0;

    for (int m = 0; m < 2; m++) begin
      frm_phase[m] = HUNT_SYNC1;
      frm_count[m] = 8'h00;
      frm_len[m]   = 8'h00;
      frm_sum[m]   = 8'h00;
      frm_msg[m]   = 1'b0;
      frm_bad[m]   = 1'b0;
      for (int i = 0; i < MAX_LEN; i++) begin
        frm_store[m][i]   = 8'h00;
        frm_written[m][i] = 1'b0;
      end
    end

    // Directed part: flags and reads straight after reset.
    queue_item(REQ_QUERY, 8'h00, 8'h00);
    queue_item(REQ_READ, 8'hFF, 8'hFF);
    // Zero length goes straight to the checksum byte.
    queue_byte(SYNC_BYTE);
    queue_byte(SYNC_BYTE);
    queue_byte(8'h00);
    queue_byte(8'h00);
    // Second frame lands over the held message; its sum wraps to zero.
    queue_byte(SYNC_BYTE);
    queue_byte(SYNC_BYTE);
    queue_byte(8'h03);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(8'h00);
    // Reads leave the message flag alone; the last one is past the length.
    queue_item(REQ_READ, 8'h00, 8'h00);
    queue_item(REQ_READ, 8'h00, 8'h02);
    queue_item(REQ_READ, 8'h00, 8'h03);
    // Length just over the limit: rejected, but kept as the stored length.
    queue_byte(SYNC_BYTE);
    queue_byte(SYNC_BYTE);
    queue_byte(8'(MAX_LEN + 1));
    // Below the stored length but past the store.
    queue_item(REQ_READ, 8'h00, 8'(MAX_LEN));
    // Bad first sync, bad second sync.
    queue_byte(8'h55);
    queue_byte(SYNC_BYTE);
    queue_byte(8'h00);
    // Query with wrong data seen drops the message; release does too.
    queue_item(REQ_QUERY, 8'h00, 8'h00);
    queue_item(REQ_RELEASE, 8'h00, 8'h00);
    // Wrong checksum.
    queue_byte(SYNC_BYTE);
    queue_byte(SYNC_BYTE);
    queue_byte(8'h01);
    queue_byte(8'h05);
    queue_byte(8'h06);

    total_items = pending_items.size();
    queue_random_part();
    total_items = pending_items.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (taken_cnt == total_items);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
